// ----- sv/rna_max_pair_fold_core_defines.svh -----
// ----------------------------------------------------------------------------
// rna_max_pair_fold_core_defines
// Assertion macros shared by the folding core.
// ----------------------------------------------------------------------------
`ifndef RNA_MAX_PAIR_FOLD_CORE_DEFINES_SVH
`define RNA_MAX_PAIR_FOLD_CORE_DEFINES_SVH

// same-cycle implication
`define RMPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RMPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpf_pkg
// Types, codes and defaults shared by the folding core modules.
// ----------------------------------------------------------------------------
package rmpf_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam logic [3:0] MIN_GAP_RST = 4'd4;

    localparam logic [1:0] SYM_DOT   = 2'd0;
    localparam logic [1:0] SYM_OPEN  = 2'd1;
    localparam logic [1:0] SYM_CLOSE = 2'd2;

    localparam logic [6:0] CH_NONE  = 7'd0;
    localparam logic [6:0] CH_PAIR  = 7'd1;
    localparam logic [6:0] CH_SKIP  = 7'd2;
    localparam logic [6:0] CH_SPLIT = 7'd3;

    typedef struct packed {
        logic [1:0] base;
        logic       last_base;
    } t_in;

    typedef struct packed {
        logic [1:0] symbol;
        logic [5:0] position;
        logic [5:0] pair_count;
        logic       overflow;
        logic       final_symbol;
    } t_out;

    typedef struct packed {
        logic in_take;
        logic span_init;
        logic enc_issue;
        logic split_step;
        logic span_write;
        logic tr_init;
        logic tr_pop;
        logic tr_latch;
        logic tr_look;
        logic tr_open;
        logic tr_close;
        logic tr_push_in;
        logic tr_push_lo;
        logic tr_push_hi;
        logic out_read;
        logic out_next;
        logic out_done;
    } t_cmd;

    typedef struct packed {
        logic short_span;
        logic k_last;
        logic j_last;
        logic i_zero;
        logic sp_zero;
        logic tr_zero;
        logic tr_pair;
        logic tr_skip;
        logic tr_split;
        logic tr_inner;
        logic p_last;
    } t_sts;

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_F_SPAN  = 17'h00002,
        ST_F_ENC   = 17'h00004,
        ST_F_SPLIT = 17'h00008,
        ST_F_DRAIN = 17'h00010,
        ST_F_WRITE = 17'h00020,
        ST_T_INIT  = 17'h00040,
        ST_T_POP   = 17'h00080,
        ST_T_READ  = 17'h00100,
        ST_T_LOOK  = 17'h00200,
        ST_T_OPEN  = 17'h00400,
        ST_T_CLOSE = 17'h00800,
        ST_T_PUSHI = 17'h01000,
        ST_T_PUSHA = 17'h02000,
        ST_T_PUSHB = 17'h04000,
        ST_O_READ  = 17'h08000,
        ST_O_SHOW  = 17'h10000
    } t_state;

endpackage

// ----- sv/rmpf_ram.sv -----
// ----------------------------------------------------------------------------
// rmpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/rmpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// rmpf_ctrl
// Sequencer for collection, table fill, traceback and symbol output.
// ----------------------------------------------------------------------------
module rmpf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    input  logic           i_out_ready,
    input  rmpf_pkg::t_sts i_sts,
    output rmpf_pkg::t_cmd o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);

    rmpf_pkg::t_state r_state;
    rmpf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmpf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rmpf_pkg::ST_IDLE: begin
                if (i_in_valid && i_last) n_state = rmpf_pkg::ST_F_SPAN;
            end
            rmpf_pkg::ST_F_SPAN: begin
                n_state = i_sts.short_span ? rmpf_pkg::ST_F_WRITE : rmpf_pkg::ST_F_ENC;
            end
            rmpf_pkg::ST_F_ENC:   n_state = rmpf_pkg::ST_F_SPLIT;
            rmpf_pkg::ST_F_SPLIT: begin
                if (i_sts.k_last) n_state = rmpf_pkg::ST_F_DRAIN;
            end
            rmpf_pkg::ST_F_DRAIN: n_state = rmpf_pkg::ST_F_WRITE;
            rmpf_pkg::ST_F_WRITE: begin
                n_state = (i_sts.j_last && i_sts.i_zero) ? rmpf_pkg::ST_T_INIT
                                                         : rmpf_pkg::ST_F_SPAN;
            end
            rmpf_pkg::ST_T_INIT:  n_state = rmpf_pkg::ST_T_POP;
            rmpf_pkg::ST_T_POP: begin
                n_state = i_sts.sp_zero ? rmpf_pkg::ST_O_READ : rmpf_pkg::ST_T_READ;
            end
            rmpf_pkg::ST_T_READ:  n_state = rmpf_pkg::ST_T_LOOK;
            rmpf_pkg::ST_T_LOOK: begin
                if (i_sts.tr_zero) begin
                    n_state = rmpf_pkg::ST_T_POP;
                end else if (i_sts.tr_pair) begin
                    n_state = rmpf_pkg::ST_T_OPEN;
                end else if (i_sts.tr_skip) begin
                    n_state = i_sts.tr_inner ? rmpf_pkg::ST_T_PUSHI : rmpf_pkg::ST_T_POP;
                end else if (i_sts.tr_split) begin
                    n_state = rmpf_pkg::ST_T_PUSHA;
                end else begin
                    n_state = rmpf_pkg::ST_T_POP;
                end
            end
            rmpf_pkg::ST_T_OPEN:  n_state = rmpf_pkg::ST_T_CLOSE;
            rmpf_pkg::ST_T_CLOSE: begin
                n_state = i_sts.tr_inner ? rmpf_pkg::ST_T_PUSHI : rmpf_pkg::ST_T_POP;
            end
            rmpf_pkg::ST_T_PUSHI: n_state = rmpf_pkg::ST_T_POP;
            rmpf_pkg::ST_T_PUSHA: n_state = rmpf_pkg::ST_T_PUSHB;
            rmpf_pkg::ST_T_PUSHB: n_state = rmpf_pkg::ST_T_POP;
            rmpf_pkg::ST_O_READ:  n_state = rmpf_pkg::ST_O_SHOW;
            rmpf_pkg::ST_O_SHOW: begin
                if (i_out_ready) begin
                    n_state = i_sts.p_last ? rmpf_pkg::ST_IDLE : rmpf_pkg::ST_O_READ;
                end
            end
            default: n_state = rmpf_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == rmpf_pkg::ST_IDLE);
    assign o_out_valid = (r_state == rmpf_pkg::ST_O_SHOW);

    always_comb begin
        o_cmd            = '0;
        o_cmd.in_take    = (r_state == rmpf_pkg::ST_IDLE) && i_in_valid;
        o_cmd.span_init  = (r_state == rmpf_pkg::ST_F_SPAN);
        o_cmd.enc_issue  = (r_state == rmpf_pkg::ST_F_ENC);
        o_cmd.split_step = (r_state == rmpf_pkg::ST_F_SPLIT);
        o_cmd.span_write = (r_state == rmpf_pkg::ST_F_WRITE);
        o_cmd.tr_init    = (r_state == rmpf_pkg::ST_T_INIT);
        o_cmd.tr_pop     = (r_state == rmpf_pkg::ST_T_POP) && !i_sts.sp_zero;
        o_cmd.tr_latch   = (r_state == rmpf_pkg::ST_T_READ);
        o_cmd.tr_look    = (r_state == rmpf_pkg::ST_T_LOOK);
        o_cmd.tr_open    = (r_state == rmpf_pkg::ST_T_OPEN);
        o_cmd.tr_close   = (r_state == rmpf_pkg::ST_T_CLOSE);
        o_cmd.tr_push_in = (r_state == rmpf_pkg::ST_T_PUSHI);
        o_cmd.tr_push_lo = (r_state == rmpf_pkg::ST_T_PUSHA);
        o_cmd.tr_push_hi = (r_state == rmpf_pkg::ST_T_PUSHB);
        o_cmd.out_read   = (r_state == rmpf_pkg::ST_O_READ);
        o_cmd.out_next   = (r_state == rmpf_pkg::ST_O_SHOW) && i_out_ready && !i_sts.p_last;
        o_cmd.out_done   = (r_state == rmpf_pkg::ST_O_SHOW) && i_out_ready && i_sts.p_last;
    end

endmodule

// ----- sv/rmpf_dpath.sv -----
// ----------------------------------------------------------------------------
// rmpf_dpath
// Sequence store, score and choice tables, trace stack and symbol store,
// with the span compare unit and all index counters.
// ----------------------------------------------------------------------------
module rmpf_dpath #(
    parameter int MAX_LEN = rmpf_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rmpf_pkg::t_cmd i_cmd,
    input  rmpf_pkg::t_in  i_in,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata,
    output rmpf_pkg::t_sts o_sts,
    output rmpf_pkg::t_out o_out
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SAW = 2 * AW;
    localparam int SD  = 1 << SAW;

    logic [LW-1:0]  r_len;
    logic           r_ovf;
    logic [3:0]     r_min_gap;
    logic [AW-1:0]  r_i, r_j, r_k, r_kd;
    logic [5:0]     r_best, r_total;
    logic [6:0]     r_ch;
    logic           r_enc_v, r_spl_v, r_rev;
    logic [LW-1:0]  r_sp;
    logic [AW-1:0]  r_ti, r_tj, r_tk, r_p;
    logic [MAX_LEN-1:0] r_symv;
    logic           r_osv;

    logic [1:0]     seqa_rd, seqb_rd;
    logic [5:0]     sca_rd, scb_rd;
    logic [6:0]     ch_rd;
    logic [SAW-1:0] stk_rd;
    logic [1:0]     sym_rd;
    logic           room;
    logic [AW-1:0]  nm1, start_idx, diff;
    logic [SAW-1:0] sca_raddr, tab_waddr, stk_wdata;
    logic           stk_we, sym_we;
    logic [AW-1:0]  sym_waddr;
    logic [1:0]     sym_wdata;
    logic           pr;
    logic [6:0]     enc_t, spl_t, cand_t, cand_ch;
    logic           cand_v;
    logic [7:0]     kx;

    assign room      = (r_len < LW'(MAX_LEN));
    assign nm1       = AW'(r_len - LW'(1));
    assign start_idx = room ? r_len[AW-1:0] : AW'(MAX_LEN - 1);
    assign diff      = r_j - r_i;
    assign tab_waddr = {r_i, r_j};

    rmpf_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_seq_a (
        .i_clk(i_clk), .i_we(i_cmd.in_take && room), .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_in.base), .i_raddr(r_i), .o_rdata(seqa_rd)
    );
    rmpf_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_seq_b (
        .i_clk(i_clk), .i_we(i_cmd.in_take && room), .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_in.base), .i_raddr(r_j), .o_rdata(seqb_rd)
    );

    always_comb begin
        if (i_cmd.tr_latch) begin
            sca_raddr = stk_rd;
        end else if (i_cmd.enc_issue) begin
            sca_raddr = {r_i + AW'(1), r_j - AW'(1)};
        end else begin
            sca_raddr = {r_i, r_k};
        end
    end

    rmpf_ram #(.WIDTH(6), .DEPTH(SD)) u_score_a (
        .i_clk(i_clk), .i_we(i_cmd.span_write), .i_waddr(tab_waddr),
        .i_wdata(r_best), .i_raddr(sca_raddr), .o_rdata(sca_rd)
    );
    rmpf_ram #(.WIDTH(6), .DEPTH(SD)) u_score_b (
        .i_clk(i_clk), .i_we(i_cmd.span_write), .i_waddr(tab_waddr),
        .i_wdata(r_best), .i_raddr({r_k + AW'(1), r_j}), .o_rdata(scb_rd)
    );
    rmpf_ram #(.WIDTH(7), .DEPTH(SD)) u_choice (
        .i_clk(i_clk), .i_we(i_cmd.span_write), .i_waddr(tab_waddr),
        .i_wdata(r_ch), .i_raddr(stk_rd), .o_rdata(ch_rd)
    );

    // candidate from the word read back in the cycle after its issue
    assign pr      = ((3'(seqa_rd) + 3'(seqb_rd)) == 3'd3);
    assign enc_t   = (r_rev ? 7'd0 : 7'(sca_rd)) + 7'(pr);
    assign spl_t   = 7'(sca_rd) + 7'(scb_rd);
    assign cand_v  = r_enc_v || r_spl_v;
    assign cand_t  = r_enc_v ? enc_t : spl_t;
    assign cand_ch = r_enc_v ? (pr ? rmpf_pkg::CH_PAIR : rmpf_pkg::CH_SKIP)
                             : rmpf_pkg::CH_SPLIT + 7'(r_kd - r_i);

    always_comb begin
        stk_we    = i_cmd.tr_init || i_cmd.tr_push_in || i_cmd.tr_push_lo
                    || i_cmd.tr_push_hi;
        stk_wdata = {r_ti, r_tk};
        if (i_cmd.tr_init) begin
            stk_wdata = {AW'(0), nm1};
        end else if (i_cmd.tr_push_in) begin
            stk_wdata = {r_ti + AW'(1), r_tj - AW'(1)};
        end else if (i_cmd.tr_push_hi) begin
            stk_wdata = {r_tk + AW'(1), r_tj};
        end
    end

    // drop pushes once the stack holds MAX_LEN words
    rmpf_ram #(.WIDTH(SAW), .DEPTH(MAX_LEN)) u_stack (
        .i_clk(i_clk), .i_we(stk_we && (r_sp < LW'(MAX_LEN))),
        .i_waddr(r_sp[AW-1:0]), .i_wdata(stk_wdata),
        .i_raddr(AW'(r_sp - LW'(1))), .o_rdata(stk_rd)
    );

    assign sym_we    = i_cmd.tr_open || i_cmd.tr_close;
    assign sym_waddr = i_cmd.tr_open ? r_ti : r_tj;
    assign sym_wdata = i_cmd.tr_open ? rmpf_pkg::SYM_OPEN : rmpf_pkg::SYM_CLOSE;

    rmpf_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_sym (
        .i_clk(i_clk), .i_we(sym_we), .i_waddr(sym_waddr),
        .i_wdata(sym_wdata), .i_raddr(r_p), .o_rdata(sym_rd)
    );

    assign kx = 8'(r_ti) + 8'(ch_rd) - 8'(rmpf_pkg::CH_SPLIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_min_gap <= rmpf_pkg::MIN_GAP_RST;
            r_enc_v   <= 1'b0;
            r_spl_v   <= 1'b0;
            r_sp      <= '0;
            r_symv    <= '0;
        end else begin
            if (i_cfg_we) r_min_gap <= i_cfg_wdata;
            r_enc_v <= i_cmd.enc_issue;
            r_spl_v <= i_cmd.split_step;
            if (i_cmd.in_take) begin
                if (room) begin
                    r_len <= r_len + LW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_done) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.tr_init) begin
                r_sp   <= LW'(1);
                r_symv <= '0;
            end else if (i_cmd.tr_pop) begin
                r_sp <= r_sp - LW'(1);
            end else if (stk_we && (r_sp < LW'(MAX_LEN))) begin
                r_sp <= r_sp + LW'(1);
            end
            if (sym_we) r_symv[sym_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kd <= r_k;
        if (i_cmd.in_take && i_in.last_base) begin
            r_i <= start_idx;
            r_j <= start_idx;
        end
        if (i_cmd.enc_issue) r_rev <= (r_j == r_i + AW'(1));
        if (cand_v && (cand_t > 7'(r_best))) begin
            r_best <= cand_t[5:0];
            r_ch   <= cand_ch;
        end
        if (i_cmd.span_init) begin
            r_best <= '0;
            r_ch   <= rmpf_pkg::CH_NONE;
            r_k    <= r_i;
        end
        if (i_cmd.split_step) r_k <= r_k + AW'(1);
        if (i_cmd.span_write) begin
            if (o_sts.j_last) begin
                if (o_sts.i_zero) begin
                    r_total <= r_best;
                end else begin
                    r_i <= r_i - AW'(1);
                    r_j <= r_i - AW'(1);
                end
            end else begin
                r_j <= r_j + AW'(1);
            end
        end
        if (i_cmd.tr_latch) begin
            r_ti <= stk_rd[SAW-1:AW];
            r_tj <= stk_rd[AW-1:0];
        end
        if (i_cmd.tr_look) r_tk <= kx[AW-1:0];
        if (i_cmd.tr_init) r_p <= '0;
        if (i_cmd.out_next) r_p <= r_p + AW'(1);
        if (i_cmd.out_read) r_osv <= r_symv[r_p];
    end

    always_comb begin
        o_sts            = '0;
        o_sts.short_span = (8'(diff) <= 8'(r_min_gap));
        o_sts.k_last     = (r_k + AW'(1) == r_j);
        o_sts.j_last     = (r_j == nm1);
        o_sts.i_zero     = (r_i == '0);
        o_sts.sp_zero    = (r_sp == '0);
        o_sts.tr_zero    = (sca_rd == 6'd0);
        o_sts.tr_pair    = (ch_rd == rmpf_pkg::CH_PAIR);
        o_sts.tr_skip    = (ch_rd == rmpf_pkg::CH_SKIP);
        o_sts.tr_split   = (ch_rd >= rmpf_pkg::CH_SPLIT) && (kx < 8'(r_tj));
        o_sts.tr_inner   = (8'(r_ti) + 8'd2 <= 8'(r_tj));
        o_sts.p_last     = (r_p == nm1);
    end

    always_comb begin
        o_out              = '0;
        o_out.symbol       = r_osv ? sym_rd : rmpf_pkg::SYM_DOT;
        o_out.position     = 6'(r_p);
        o_out.pair_count   = r_total;
        o_out.overflow     = r_ovf;
        o_out.final_symbol = (r_p == nm1);
    end

endmodule

// ----- sv/rna_max_pair_fold_core.sv -----
// ----------------------------------------------------------------------------
// rna_max_pair_fold_core
// Maximum base-pair folding of one RNA sequence, emitted as dot-bracket.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one base per word, last_base ends
// the sequence. Bases past MAX_LEN are dropped and flag overflow; a dropped
// last base still starts the fold. After a non-last word the block stays
// ready for the next. After the last word the block fills the score table
// span by span through the two score RAM read ports; a span with j - i up to
// min_gap is written as zero, unscored. Traceback then walks the stack RAM
// one span at a time, and symbols leave on the output channel
// (o_out_valid / i_out_ready) one word at a time, each read from the symbol
// store before it is shown, positions in order, final_symbol on the last. A
// stalled receiver holds the current word and the sequencer with it. No input
// is taken until the last symbol has gone. Synchronous active-low reset
// empties the sequence, clears overflow and sets min_gap to 4; tables need
// no clearing, every entry is written before it is read.
// ----------------------------------------------------------------------------
`include "rna_max_pair_fold_core_defines.svh"

module rna_max_pair_fold_core #(
    parameter int MAX_LEN = rmpf_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rmpf_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rmpf_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_wdata
);

    rmpf_pkg::t_cmd cmd;
    rmpf_pkg::t_sts sts;

    rmpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in.last_base),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    rmpf_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_out       (o_out)
    );

    `RMPF_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid, "input taken while output pending")
    `RMPF_ASSERT_NEXT(a_stay_busy, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out.final_symbol, !o_in_ready, "idle before final symbol")
    `RMPF_ASSERT_NEXT(a_back_idle, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out.final_symbol, o_in_ready, "not idle after final symbol")

endmodule

// ----- bench/rna_max_pair_fold_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_max_pair_fold_core_tb
// Sends RNA sequences base by base and checks every dot-bracket word against
// a local maximum-pair fold, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module rna_max_pair_fold_core_tb;

    localparam int NMAX = rmpf_pkg::MAX_LEN_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    rmpf_pkg::t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    rmpf_pkg::t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [3:0] i_cfg_wdata = '0;

    rna_max_pair_fold_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    rmpf_pkg::t_in  base_queue[$];
    rmpf_pkg::t_out symbol_queue[$];
    int   mismatch_count = 0;
    bit   hold_off = 1'b0;
    bit   start_hold = 1'b0;

    // folding model state
    logic [1:0] seq_bases[NMAX];
    int   seq_len = 0;
    bit   seq_overflow = 1'b0;
    logic [3:0] gap_setting = rmpf_pkg::MIN_GAP_RST;
    logic [5:0] span_score[NMAX][NMAX];
    logic [6:0] span_choice[NMAX][NMAX];

    function automatic int score_of(int i, int j);
        if (i < 0 || j >= NMAX || i > j) return 0;
        return span_score[i][j];
    endfunction

    task automatic fold_and_predict();
        logic [1:0] sym[NMAX];
        int stk_i[$];
        int stk_j[$];
        int best, t, i, j, k, p, total;
        logic [6:0] ch;
        rmpf_pkg::t_out w;
        for (i = 0; i < NMAX; i++) sym[i] = rmpf_pkg::SYM_DOT;
        for (i = seq_len - 1; i >= 0; i--) begin
            for (j = i; j < seq_len; j++) begin
                best = 0;
                ch = rmpf_pkg::CH_NONE;
                if (j - i > gap_setting) begin
                    p = (seq_bases[i] + seq_bases[j] == 3) ? 1 : 0;
                    t = score_of(i + 1, j - 1) + p;
                    if (t > best) begin
                        best = t;
                        ch = p ? rmpf_pkg::CH_PAIR : rmpf_pkg::CH_SKIP;
                    end
                    for (k = i; k < j; k++) begin
                        t = score_of(i, k) + score_of(k + 1, j);
                        if (t > best) begin
                            best = t;
                            ch = rmpf_pkg::CH_SPLIT + 7'(k - i);
                        end
                    end
                end
                span_score[i][j] = 6'(best);
                span_choice[i][j] = ch;
            end
        end
        stk_i = {stk_i, 0};
        stk_j = {stk_j, seq_len - 1};
        while (stk_i.size() > 0) begin
            i = stk_i.pop_back();
            j = stk_j.pop_back();
            if (score_of(i, j) == 0) continue;
            ch = span_choice[i][j];
            if (ch == rmpf_pkg::CH_PAIR || ch == rmpf_pkg::CH_SKIP) begin
                if (ch == rmpf_pkg::CH_PAIR) begin
                    sym[i] = rmpf_pkg::SYM_OPEN;
                    sym[j] = rmpf_pkg::SYM_CLOSE;
                end
                if (j >= 2 && i + 1 <= j - 1) begin
                    stk_i = {stk_i, i + 1};
                    stk_j = {stk_j, j - 1};
                end
            end else if (ch >= rmpf_pkg::CH_SPLIT) begin
                k = i + (ch - rmpf_pkg::CH_SPLIT);
                if (k < j) begin
                    stk_i = {stk_i, i}; stk_j = {stk_j, k};
                    stk_i = {stk_i, k + 1}; stk_j = {stk_j, j};
                end
            end
        end
        total = score_of(0, seq_len - 1);
        for (p = 0; p < seq_len; p++) begin
            w.symbol = sym[p];
            w.position = 6'(p);
            w.pair_count = 6'(total);
            w.overflow = seq_overflow;
            w.final_symbol = (p + 1 == seq_len);
            symbol_queue = {symbol_queue, w};
        end
        seq_len = 0;
        seq_overflow = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input rmpf_pkg::t_out got,
                                   input rmpf_pkg::t_out want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver: take the model step on acceptance
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            if (seq_len < NMAX) begin
                seq_bases[seq_len] = i_in.base;
                seq_len++;
            end else begin
                seq_overflow = 1'b1;
            end
            if (i_in.last_base) fold_and_predict();
        end
        if (!i_in_valid || o_in_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (i_rst_n && base_queue.size() > 0) begin
                i_in <= base_queue.pop_front();
                i_in_valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    int stall = 0;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (symbol_queue.size() == 0) begin
                report_mismatch("unexpected word", o_out, '0);
            end else begin
                rmpf_pkg::t_out want;
                want = symbol_queue.pop_front();
                if (o_out.symbol !== want.symbol) report_mismatch("symbol", o_out, want);
                if (o_out.position !== want.position)
                    report_mismatch("position", o_out, want);
                if (o_out.pair_count !== want.pair_count)
                    report_mismatch("pair_count", o_out, want);
                if (o_out.overflow !== want.overflow)
                    report_mismatch("overflow", o_out, want);
                if (o_out.final_symbol !== want.final_symbol)
                    report_mismatch("final_symbol", o_out, want);
            end
        end
        if (hold_off || !i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall <= pick_gap();
        end
    end

    // long receiver hold-off, counted here
    initial begin
        wait (start_hold);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic add_seq(input int len, input int kind);
        rmpf_pkg::t_in b;
        for (int p = 0; p < len; p++) begin
            case (kind)
                0: b.base = 2'($urandom_range(0, 3));
                1: b.base = (p < len / 2) ? 2'(p % 2) : 2'(3 - ((len - 1 - p) % 2));
                default: b.base = 2'(kind - 2);
            endcase
            b.last_base = (p == len - 1);
            base_queue = {base_queue, b};
        end
    endtask

    task automatic wait_idle();
        while (base_queue.size() > 0 || i_in_valid || symbol_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_gap(input logic [3:0] g);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= g;
        gap_setting = g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: default gap, single base, all-same, stems
        add_seq(1, 0);
        add_seq(6, 2);
        add_seq(12, 1);
        wait_idle();
        set_gap(4'd0);
        add_seq(2, 0);
        add_seq(2, 4);
        wait_idle();
        // fill while the receiver holds off
        start_hold = 1'b1;
        add_seq(6, 5);
        add_seq(5, 3);
        wait_idle();
        set_gap(4'd15);
        add_seq(10, 1);
        wait_idle();
        set_gap(4'd8);
        // overflow: 70 bases, truncated to 64
        add_seq(70, 0);
        wait_idle();
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            set_gap(4'($urandom_range(0, 8)));
            while (sent < (phase + 1) * 23) begin
                len = $urandom_range(1, 14);
                add_seq(len, ($urandom_range(0, 3) == 0) ? 1 : 0);
                sent += len;
            end
            wait_idle();
        end
        add_seq(64, 0);
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
